>>> design/csbm_pkg.sv
// shared types and constants of the cell scan balance monitor
package csbm_pkg;

  localparam int CELLS = 8;
  localparam int POS_W = $clog2(CELLS);
  localparam int MV_W = 13;
  localparam int IDX_W = 3;
  localparam int THR_W = 10;
  localparam int CFG_IDX_W = 1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [MV_W-1:0] mv_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [THR_W-1:0] thr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam pos_t LAST_POS = pos_t'(CELLS - 1);
  localparam mv_t LEVEL_START_LOW = mv_t'(5000);
  localparam thr_t CHANGE_THR_RESET = thr_t'(20);
  localparam thr_t IMBAL_THR_RESET = thr_t'(50);

  // register indexes of the configuration port
  localparam cfg_idx_t REG_CHANGE_THR = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMBAL_THR = cfg_idx_t'(1);

  // extremes and balancing state as shown with each result item
  typedef struct packed {
    pos_t lowest_index;
    mv_t  lowest_level;
    pos_t highest_index;
    mv_t  highest_level;
    logic balancing;
    logic changed;
  } scan_view_t;

endpackage

>>> design/csbm_in_if.sv
// input channel: one cell sample per item
interface csbm_in_if;
  logic valid;
  logic ready;
  logic [csbm_pkg::MV_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink (input valid, input sample_mv, output ready);
endinterface

>>> design/csbm_out_if.sv
// output channel: one result item per sample
interface csbm_out_if;
  logic valid;
  logic ready;
  logic [csbm_pkg::IDX_W-1:0] cell_index;
  logic voltage_changed;
  logic scan_complete;
  logic [csbm_pkg::IDX_W-1:0] lowest_cell;
  logic [csbm_pkg::MV_W-1:0] lowest_mv;
  logic [csbm_pkg::IDX_W-1:0] highest_cell;
  logic [csbm_pkg::MV_W-1:0] highest_mv;
  logic balancing;
  logic balancing_changed;

  modport source (output valid, output cell_index, output voltage_changed,
                  output scan_complete, output lowest_cell, output lowest_mv,
                  output highest_cell, output highest_mv, output balancing,
                  output balancing_changed, input ready);
  modport sink (input valid, input cell_index, input voltage_changed,
                input scan_complete, input lowest_cell, input lowest_mv,
                input highest_cell, input highest_mv, input balancing,
                input balancing_changed, output ready);
endinterface

>>> design/csbm_extremes.sv
// running min/max search over one scan, committed at the last cell
module csbm_extremes (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  csbm_pkg::pos_t       pos,
  input  csbm_pkg::mv_t        sample,
  input  csbm_pkg::thr_t       imbal_thr,
  output csbm_pkg::scan_view_t view_next
);

  // running search state, valid from the first cell of a scan on
  csbm_pkg::mv_t  run_lo;
  csbm_pkg::pos_t run_lo_idx;
  csbm_pkg::mv_t  run_hi;
  csbm_pkg::pos_t run_hi_idx;
  logic           run_moved;

  // committed result of the last full scan
  csbm_pkg::scan_view_t view;

  csbm_pkg::mv_t  base_lo;
  csbm_pkg::pos_t base_lo_idx;
  csbm_pkg::mv_t  base_hi;
  csbm_pkg::pos_t base_hi_idx;
  logic           base_moved;
  logic           lo_take;
  logic           hi_take;
  csbm_pkg::mv_t  new_lo;
  csbm_pkg::pos_t new_lo_idx;
  csbm_pkg::mv_t  new_hi;
  csbm_pkg::pos_t new_hi_idx;
  logic           new_moved;
  logic signed [csbm_pkg::MV_W:0] spread;
  logic           want;
  logic           complete;

  always_comb begin
    // first cell restarts the search from the committed indexes
    if (pos == '0) begin
      base_lo     = csbm_pkg::LEVEL_START_LOW;
      base_lo_idx = view.lowest_index;
      base_hi     = '0;
      base_hi_idx = view.highest_index;
      base_moved  = 1'b0;
    end else begin
      base_lo     = run_lo;
      base_lo_idx = run_lo_idx;
      base_hi     = run_hi;
      base_hi_idx = run_hi_idx;
      base_moved  = run_moved;
    end
    lo_take    = sample < base_lo;
    hi_take    = sample > base_hi;
    new_lo     = lo_take ? sample : base_lo;
    new_lo_idx = lo_take ? pos : base_lo_idx;
    new_hi     = hi_take ? sample : base_hi;
    new_hi_idx = hi_take ? pos : base_hi_idx;
    new_moved  = base_moved | (lo_take && (base_lo_idx != pos))
                            | (hi_take && (base_hi_idx != pos));
    spread = $signed({1'b0, new_hi}) - $signed({1'b0, new_lo});
    want   = spread > $signed({{(csbm_pkg::MV_W + 1 - csbm_pkg::THR_W){1'b0}}, imbal_thr});
    complete = pos == csbm_pkg::LAST_POS;
    if (complete) begin
      view_next.lowest_index  = new_lo_idx;
      view_next.lowest_level  = new_lo;
      view_next.highest_index = new_hi_idx;
      view_next.highest_level = new_hi;
      view_next.balancing     = want;
      view_next.changed       = new_moved | (want != view.balancing);
    end else begin
      view_next = view;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view.lowest_index  <= '0;
      view.lowest_level  <= csbm_pkg::LEVEL_START_LOW;
      view.highest_index <= '0;
      view.highest_level <= '0;
      view.balancing     <= 1'b0;
      view.changed       <= 1'b0;
    end else if (upd) begin
      view <= view_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      run_lo     <= new_lo;
      run_lo_idx <= new_lo_idx;
      run_hi     <= new_hi;
      run_hi_idx <= new_hi_idx;
      run_moved  <= new_moved;
    end
  end

endmodule

>>> design/cell_scan_balance_monitor.sv
// top level of the cell scan balance monitor
// Takes one cell voltage per item and assigns it round robin to cells 0 to
// CELLS-1; every item yields exactly one result item. Throughput is one item
// per cycle while out_ch.ready stays high; the read stage stalls while the
// output register holds a result not yet taken. The cell store is a synchronous
// memory read at acceptance, and the compare, store write-back and running
// min/max step happen as the item moves into the output register. The output
// register lets a new item be accepted while a result waits to be taken.
// Consecutive items always address different cells, so a read never meets a
// pending write to the same entry. The min/max search runs incrementally over
// the scan and is committed on the last cell, where the extremes, balancing
// and balancing_changed update; between scans they hold. Per-entry valid bits
// make never-written cells read as zero right after reset, with no clearing
// pass. The two thresholds are to be written through the cfg port only while
// the block is idle; the user must keep to this, the block does not enforce it.
module cell_scan_balance_monitor (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  csbm_pkg::cfg_idx_t  cfg_index,
  input  csbm_pkg::thr_t      cfg_data,
  csbm_in_if.sink             in_ch,
  csbm_out_if.source          out_ch
);

  // configuration registers
  csbm_pkg::thr_t change_thr;
  csbm_pkg::thr_t imbal_thr;

  // scan position of the last accepted item
  csbm_pkg::pos_t scan_position;
  csbm_pkg::pos_t pos_next;

  // cell store memory and per-entry valid bits
  csbm_pkg::mv_t  cell_mem [csbm_pkg::CELLS];
  logic [csbm_pkg::CELLS-1:0] entry_valid;
  csbm_pkg::mv_t  rd_data;
  logic           rd_valid;

  // read stage
  logic           s1_valid;
  csbm_pkg::pos_t s1_pos;
  csbm_pkg::mv_t  s1_sample;
  logic           s1_adv;
  logic           in_accept;

  // compare stage
  csbm_pkg::mv_t  old_mv;
  csbm_pkg::mv_t  diff_mv;
  logic           changed;
  csbm_pkg::scan_view_t view_next;

  // output register
  logic                 out_valid;
  csbm_pkg::idx_t       out_cell;
  logic                 out_changed;
  logic                 out_complete;
  csbm_pkg::scan_view_t out_view;

  assign s1_adv    = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign pos_next  = (scan_position == csbm_pkg::LAST_POS) ? '0 : scan_position + 1'b1;

  // config writes, unknown indexes cannot occur with a one-bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      change_thr <= csbm_pkg::CHANGE_THR_RESET;
      imbal_thr  <= csbm_pkg::IMBAL_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csbm_pkg::REG_CHANGE_THR: change_thr <= cfg_data;
        csbm_pkg::REG_IMBAL_THR:  imbal_thr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // position advance and read-stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= csbm_pkg::LAST_POS;
      s1_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        scan_position <= pos_next;
      end
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos    <= pos_next;
      s1_sample <= in_ch.sample_mv;
    end
  end

  // memory: read at acceptance, write back as the item leaves the read stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cell_mem[s1_pos] <= s1_sample;
    end
    if (in_accept) begin
      rd_data <= cell_mem[pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (s1_adv) begin
        entry_valid[s1_pos] <= 1'b1;
      end
      if (in_accept) begin
        rd_valid <= entry_valid[pos_next];
      end
    end
  end

  // change detect against the stored value, unwritten cells read as zero
  always_comb begin
    old_mv  = rd_valid ? rd_data : '0;
    diff_mv = (s1_sample >= old_mv) ? s1_sample - old_mv : old_mv - s1_sample;
    changed = diff_mv > {{(csbm_pkg::MV_W - csbm_pkg::THR_W){1'b0}}, change_thr};
  end

  csbm_extremes u_extremes (
    .clk       (clk),
    .rst       (rst),
    .upd       (s1_adv),
    .pos       (s1_pos),
    .sample    (s1_sample),
    .imbal_thr (imbal_thr),
    .view_next (view_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cell     <= csbm_pkg::idx_t'(s1_pos);
      out_changed  <= changed;
      out_complete <= s1_pos == csbm_pkg::LAST_POS;
      out_view     <= view_next;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.cell_index        = out_cell;
  assign out_ch.voltage_changed   = out_changed;
  assign out_ch.scan_complete     = out_complete;
  assign out_ch.lowest_cell       = csbm_pkg::idx_t'(out_view.lowest_index);
  assign out_ch.lowest_mv         = out_view.lowest_level;
  assign out_ch.highest_cell      = csbm_pkg::idx_t'(out_view.highest_index);
  assign out_ch.highest_mv        = out_view.highest_level;
  assign out_ch.balancing         = out_view.balancing;
  assign out_ch.balancing_changed = out_view.changed;

`ifndef NO_ASSERTIONS
  // a finished scan is always reported on the last cell
  a_complete_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_complete |-> out_cell == csbm_pkg::idx_t'(csbm_pkg::LAST_POS))
    else $error("scan complete reported on a cell other than the last");

  // a stalled read stage keeps its item and its read data
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_pos) && $stable(rd_data))
    else $error("read stage lost its item while stalled");

  // balancing implies a positive spread
  a_bal_spread: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_complete && out_view.balancing
      |-> out_view.highest_level > out_view.lowest_level)
    else $error("balancing set without a spread");
`endif

endmodule

>>> dv/cell_scan_balance_monitor_tb.sv
// self-checking testbench of the cell scan balance monitor
module cell_scan_balance_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one result item as the block should present it
  typedef struct packed {
    csbm_pkg::idx_t cell_index;
    logic           voltage_changed;
    logic           scan_complete;
    csbm_pkg::idx_t lowest_cell;
    csbm_pkg::mv_t  lowest_mv;
    csbm_pkg::idx_t highest_cell;
    csbm_pkg::mv_t  highest_mv;
    logic           balancing;
    logic           balancing_changed;
  } monitor_result_t;

  localparam int MV_MAX = (1 << csbm_pkg::MV_W) - 1;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  csbm_pkg::cfg_idx_t cfg_index;
  csbm_pkg::thr_t     cfg_data;

  csbm_in_if  in_ch ();
  csbm_out_if out_ch ();

  cell_scan_balance_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // predicted block state: thresholds, per-cell levels, scan position, extremes
  csbm_pkg::thr_t thr_change;
  csbm_pkg::thr_t thr_imbal;
  csbm_pkg::mv_t  stored_mv [csbm_pkg::CELLS];
  csbm_pkg::pos_t cur_pos;
  csbm_pkg::pos_t low_idx;
  csbm_pkg::pos_t high_idx;
  csbm_pkg::mv_t  low_mv;
  csbm_pkg::mv_t  high_mv;
  logic           bal_on;
  logic           bal_moved;

  // results predicted for accepted items, oldest first
  monitor_result_t expected_results [$];

  int errors = 0;

  // sender burst shaping
  int burst_left = 0;

  // shape of the voltages used for the current scan
  int cluster_base = 3600;
  int cluster_half = 25;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_prediction();
    thr_change = csbm_pkg::CHANGE_THR_RESET;
    thr_imbal  = csbm_pkg::IMBAL_THR_RESET;
    foreach (stored_mv[i]) stored_mv[i] = '0;
    cur_pos   = csbm_pkg::LAST_POS;
    low_idx   = '0;
    high_idx  = '0;
    low_mv    = csbm_pkg::LEVEL_START_LOW;
    high_mv   = '0;
    bal_on    = 1'b0;
    bal_moved = 1'b0;
  endfunction

  function automatic csbm_pkg::pos_t next_position();
    return (cur_pos >= csbm_pkg::LAST_POS) ? csbm_pkg::pos_t'(0)
                                           : csbm_pkg::pos_t'(cur_pos + 1'b1);
  endfunction

  // assign one sample, store it and, on the last cell, redo the extremes
  function automatic monitor_result_t predict_scan_result(csbm_pkg::mv_t sample);
    monitor_result_t r;
    csbm_pkg::pos_t  pos;
    csbm_pkg::mv_t   prev;
    csbm_pkg::mv_t   diff;
    csbm_pkg::mv_t   lo;
    csbm_pkg::mv_t   hi;
    logic            moved;
    logic            want_bal;

    pos = next_position();
    cur_pos = pos;
    prev = stored_mv[pos];
    diff = (sample >= prev) ? csbm_pkg::mv_t'(sample - prev) : csbm_pkg::mv_t'(prev - sample);
    r.voltage_changed = (diff > thr_change);
    stored_mv[pos] = sample;
    r.scan_complete = (pos == csbm_pkg::LAST_POS);

    if (r.scan_complete) begin
      // strict compares from fixed start levels, first index wins a tie
      lo = csbm_pkg::LEVEL_START_LOW;
      hi = '0;
      moved = 1'b0;
      for (int i = 0; i < csbm_pkg::CELLS; i++) begin
        if (stored_mv[i] < lo) begin
          lo = stored_mv[i];
          if (low_idx != csbm_pkg::pos_t'(i)) begin
            low_idx = csbm_pkg::pos_t'(i);
            moved = 1'b1;
          end
        end
        if (stored_mv[i] > hi) begin
          hi = stored_mv[i];
          if (high_idx != csbm_pkg::pos_t'(i)) begin
            high_idx = csbm_pkg::pos_t'(i);
            moved = 1'b1;
          end
        end
      end
      low_mv  = lo;
      high_mv = hi;
      want_bal = (int'(hi) - int'(lo)) > int'(thr_imbal);
      if (want_bal != bal_on) begin
        bal_on = want_bal;
        moved = 1'b1;
      end
      bal_moved = moved;
    end

    // index fields carry the whole cell number, as idx_t is as wide as pos_t
    r.cell_index        = csbm_pkg::idx_t'(pos);
    r.lowest_cell       = csbm_pkg::idx_t'(low_idx);
    r.lowest_mv         = low_mv;
    r.highest_cell      = csbm_pkg::idx_t'(high_idx);
    r.highest_mv        = high_mv;
    r.balancing         = bal_on;
    r.balancing_changed = bal_moved;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // pick the next voltage; a new cluster is chosen at the start of each scan
  function automatic csbm_pkg::mv_t pick_sample();
    int             v;
    int             sel;
    csbm_pkg::pos_t nxt;

    nxt = next_position();
    if (nxt == csbm_pkg::pos_t'(0)) begin
      case ($urandom_range(0, 9))
        0:       cluster_base = $urandom_range(0, 200);
        1:       cluster_base = $urandom_range(4900, 5100);
        2:       cluster_base = $urandom_range(5000, MV_MAX);
        default: cluster_base = $urandom_range(2800, 4300);
      endcase
      // spread around the imbalance limit so balancing toggles
      cluster_half = $urandom_range(0, int'(thr_imbal) / 2 + 20);
      if ($urandom_range(0, 7) == 0) cluster_half = 0; // equal cluster values give ties
    end

    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      v = cluster_base + $urandom_range(0, 2 * cluster_half) - cluster_half;
    end else if (sel < 80) begin
      // just below, at and just above the change limit
      v = int'(thr_change) + $urandom_range(0, 2) - 1;
      v = ($urandom_range(0, 1) == 1) ? int'(stored_mv[nxt]) + v : int'(stored_mv[nxt]) - v;
    end else if (sel < 92) begin
      v = $urandom_range(0, MV_MAX);
    end else begin
      case ($urandom_range(0, 4))
        0:       v = 0;
        1:       v = MV_MAX;
        2:       v = 4999;
        3:       v = 5001;
        default: v = int'(csbm_pkg::LEVEL_START_LOW);
      endcase
    end
    if (v < 0) v = 0;
    if (v > MV_MAX) v = MV_MAX;
    return csbm_pkg::mv_t'(v);
  endfunction

  // present one item, wait for it to be taken, record its expected result;
  // valid stays high so the next item can follow back to back
  task automatic send_sample(input csbm_pkg::mv_t mv);
    int gap;

    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_mv <= mv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(predict_scan_result(mv));
    burst_left--;
  endtask

  // hold the input low until every result item is back, then a little more
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both thresholds back to back; caller makes sure the block is idle
  task automatic write_thresholds(input csbm_pkg::thr_t change_mv,
                                  input csbm_pkg::thr_t imbal_mv);
    cfg_we    <= 1'b1;
    cfg_index <= csbm_pkg::REG_CHANGE_THR;
    cfg_data  <= change_mv;
    @(posedge clk);
    cfg_index <= csbm_pkg::REG_IMBAL_THR;
    cfg_data  <= imbal_mv;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_change = change_mv;
    thr_imbal  = imbal_mv;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < 50)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    monitor_result_t want_r;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item, cell_index", 16'(out_ch.cell_index),
                        16'd0);
      end else begin
        want_r = expected_results.pop_front();
        check_field("cell_index", 16'(out_ch.cell_index), 16'(want_r.cell_index));
        check_field("voltage_changed", 16'(out_ch.voltage_changed),
                    16'(want_r.voltage_changed));
        check_field("scan_complete", 16'(out_ch.scan_complete), 16'(want_r.scan_complete));
        check_field("lowest_cell", 16'(out_ch.lowest_cell), 16'(want_r.lowest_cell));
        check_field("lowest_mv", 16'(out_ch.lowest_mv), 16'(want_r.lowest_mv));
        check_field("highest_cell", 16'(out_ch.highest_cell), 16'(want_r.highest_cell));
        check_field("highest_mv", 16'(out_ch.highest_mv), 16'(want_r.highest_mv));
        check_field("balancing", 16'(out_ch.balancing), 16'(want_r.balancing));
        check_field("balancing_changed", 16'(out_ch.balancing_changed),
                    16'(want_r.balancing_changed));
      end
    end
  end

  // receiver back-pressure: long ready runs, choppy stretches and stalls
  initial begin : drive_ready
    int   hold;
    logic level;
    hold  = 0;
    level = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            level = 1'b1;
            hold  = $urandom_range(1, 40);
          end
          4, 5, 6: begin
            level = 1'($urandom_range(0, 1));
            hold  = 0;
          end
          7, 8: begin
            level = 1'b0;
            hold  = $urandom_range(0, 2);
          end
          default: begin
            level = 1'b0;
            hold  = $urandom_range(4, 12);
          end
        endcase
      end
      out_ch.ready <= level;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // three hand-made scans at the reset thresholds (change 20, spread 50)
  task automatic test_directed_scans();
    // first scan: the first seven items still show the reset view;
    // 20 is not a change from 0, 21 is; the full-scale value shows up twice
    // and the first of them must win as highest; 5000 and the values around
    // it check the start level of the lowest search
    send_sample(csbm_pkg::mv_t'(20));
    send_sample(csbm_pkg::mv_t'(21));
    send_sample(csbm_pkg::mv_t'(0));
    send_sample(csbm_pkg::mv_t'(MV_MAX));
    send_sample(csbm_pkg::mv_t'(5000));
    send_sample(csbm_pkg::mv_t'(5001));
    send_sample(csbm_pkg::mv_t'(4999));
    send_sample(csbm_pkg::mv_t'(MV_MAX));
    // second scan: nothing below 5000, so lowest reads 5000 and keeps its index
    send_sample(csbm_pkg::mv_t'(5000));
    send_sample(csbm_pkg::mv_t'(6000));
    send_sample(csbm_pkg::mv_t'(MV_MAX));
    send_sample(csbm_pkg::mv_t'(5000));
    send_sample(csbm_pkg::mv_t'(7000));
    send_sample(csbm_pkg::mv_t'(5000));
    send_sample(csbm_pkg::mv_t'(5000));
    send_sample(csbm_pkg::mv_t'(5000));
    // third scan: all zero, highest reads 0 and keeps its index, balancing drops
    repeat (csbm_pkg::CELLS) send_sample(csbm_pkg::mv_t'(0));
    wait_idle();
  endtask

  // both thresholds at zero and then at 1000
  task automatic test_threshold_limits();
    write_thresholds(csbm_pkg::thr_t'(0), csbm_pkg::thr_t'(0));
    repeat (3 * csbm_pkg::CELLS) send_sample(pick_sample());
    wait_idle();
    write_thresholds(csbm_pkg::thr_t'(1000), csbm_pkg::thr_t'(1000));
    repeat (3 * csbm_pkg::CELLS) send_sample(pick_sample());
    wait_idle();
  endtask

  // long random phases, each with its own thresholds
  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0)
        write_thresholds(csbm_pkg::CHANGE_THR_RESET, csbm_pkg::IMBAL_THR_RESET);
      else
        write_thresholds(csbm_pkg::thr_t'($urandom_range(0, 1000)),
                         csbm_pkg::thr_t'($urandom_range(0, 1000)));
      for (int n = 0; n < 400; n++) begin
        // once, let the block drain completely in the middle of a phase
        if (phase == 2 && n == 200) wait_idle();
        send_sample(pick_sample());
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= csbm_pkg::REG_CHANGE_THR;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_mv <= '0;
    reset_prediction();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_scans();
    test_threshold_limits();
    test_random_phases();

    // everything returned; allow a few more cycles for stray result items
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[cell_scan_balance_monitor] OK");
    end else begin
      $display("[cell_scan_balance_monitor] ERROR");
    end
    $finish;
  end

  // about 2100 items; even with the longest sender gap and receiver stall on
  // every item the run ends well before the timeout below
  initial begin
    #2_000_000;
    $display("[cell_scan_balance_monitor] ERROR");
    $finish;
  end

endmodule
